### hdl/rwsp_pkg.sv
// Package for the RIFF/WAVE stream parser: tags, result codes, result record.
// No dependencies; used by every module of the parser.
package rwsp_pkg;

    // Chunk and form tags as they arrive, first byte in the high bits
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Bytes of the fmt chunk kept (extended format header)
    localparam int FMT_CAP   = 18;
    localparam int FMT_POS_W = $clog2(FMT_CAP + 1);

    // Result kinds
    localparam logic [2:0] KIND_SAMPLE   = 3'd0;
    localparam logic [2:0] KIND_FORMAT   = 3'd1;
    localparam logic [2:0] KIND_DATA     = 3'd2;
    localparam logic [2:0] KIND_BAD_RIFF = 3'd3;
    localparam logic [2:0] KIND_BAD_WAVE = 3'd4;
    localparam logic [2:0] KIND_NO_FMT   = 3'd5;
    localparam logic [2:0] KIND_NO_DATA  = 3'd6;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  sample_byte;
        logic        last_sample;
        logic [31:0] data_size;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [15:0] extra_size;
    } t_result;

endpackage

### hdl/rwsp_parser.sv
// Parse state machine: tags, sizes, byte counts, fmt capture, result forming.
// Depends on rwsp_pkg.
module rwsp_parser
    import rwsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output logic       o_res_valid,
    output t_result    o_res
);

    // Parse phases
    localparam logic [3:0] PH_RIFF  = 4'd0;
    localparam logic [3:0] PH_RSIZE = 4'd1;
    localparam logic [3:0] PH_WAVE  = 4'd2;
    localparam logic [3:0] PH_ID1   = 4'd3;
    localparam logic [3:0] PH_SZ1   = 4'd4;
    localparam logic [3:0] PH_FMT   = 4'd5;
    localparam logic [3:0] PH_SKIP1 = 4'd6;
    localparam logic [3:0] PH_ID2   = 4'd7;
    localparam logic [3:0] PH_SZ2   = 4'd8;
    localparam logic [3:0] PH_SKIP2 = 4'd9;
    localparam logic [3:0] PH_DATA  = 4'd10;
    localparam logic [3:0] PH_IDLE  = 4'd11;

    logic [3:0]           r_phase, n_phase;
    logic [1:0]           r_idx, n_idx;
    logic [31:0]          r_tag, n_tag;
    logic [31:0]          r_size, n_size;
    logic [31:0]          r_left, n_left;
    logic [FMT_POS_W-1:0] r_pos, n_pos;
    logic [FMT_POS_W-1:0] r_cap, n_cap;
    logic                 r_seen, n_seen;
    logic [7:0]           r_store [FMT_CAP];
    logic [7:0]           n_store [FMT_CAP];

    logic        hdr_done;
    logic [31:0] tag_in;
    logic [31:0] size_in;
    logic        left_end;
    logic        res_valid;
    logic [2:0]  kind;
    logic [7:0]  sample;
    logic        last;
    logic [31:0] dsize;
    logic        err_valid;
    logic [2:0]  err_kind;

    assign hdr_done = (r_idx == 2'd3);
    assign tag_in   = {r_tag[23:0], i_byte};
    assign size_in  = {i_byte, r_size[31:8]};
    assign left_end = (r_left == 32'd1);

    // Next state and result for the byte on the input
    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_tag     = r_tag;
        n_size    = r_size;
        n_left    = r_left;
        n_pos     = r_pos;
        n_cap     = r_cap;
        n_seen    = r_seen;
        n_store   = r_store;
        res_valid = 1'b0;
        kind      = KIND_SAMPLE;
        sample    = 8'd0;
        last      = 1'b0;
        dsize     = 32'd0;

        unique case (r_phase)
            PH_RIFF, PH_WAVE, PH_ID1, PH_ID2: begin
                n_tag = tag_in;
                n_idx = r_idx + 2'd1;
                if (hdr_done) begin
                    unique case (r_phase)
                        PH_RIFF: begin
                            if (tag_in == TAG_RIFF) begin
                                n_phase = PH_RSIZE;
                            end else begin
                                res_valid = 1'b1;
                                kind      = KIND_BAD_RIFF;
                                n_phase   = PH_IDLE;
                            end
                        end
                        PH_WAVE: begin
                            if (tag_in == TAG_WAVE) begin
                                n_phase = PH_ID1;
                            end else begin
                                res_valid = 1'b1;
                                kind      = KIND_BAD_WAVE;
                                n_phase   = PH_IDLE;
                            end
                        end
                        PH_ID1:  n_phase = PH_SZ1;
                        default: n_phase = PH_SZ2;
                    endcase
                end
            end
            PH_RSIZE: begin
                n_size = size_in;
                n_idx  = r_idx + 2'd1;
                if (hdr_done) begin
                    n_phase = PH_WAVE;
                end
            end
            PH_SZ1: begin
                n_size = size_in;
                n_idx  = r_idx + 2'd1;
                if (hdr_done) begin
                    if (r_tag == TAG_FMT) begin
                        for (int i = 0; i < FMT_CAP; i++) begin
                            n_store[i] = 8'd0;
                        end
                        n_pos = '0;
                        if (size_in == 32'd0) begin
                            n_seen    = 1'b1;
                            res_valid = 1'b1;
                            kind      = KIND_FORMAT;
                            n_phase   = PH_ID2;
                        end else begin
                            n_left  = size_in;
                            n_cap   = (size_in < 32'(FMT_CAP)) ?
                                      size_in[FMT_POS_W-1:0] : FMT_POS_W'(FMT_CAP);
                            n_phase = PH_FMT;
                        end
                    end else if (size_in == 32'd0) begin
                        n_phase = PH_ID1;
                    end else begin
                        n_left  = size_in;
                        n_phase = PH_SKIP1;
                    end
                end
            end
            PH_FMT: begin
                // capture up to the cap, count down the whole chunk
                if (r_pos < FMT_POS_W'(FMT_CAP)) begin
                    n_store[r_pos] = i_byte;
                    n_pos          = r_pos + 1'b1;
                    if (r_pos + 1'b1 == r_cap) begin
                        n_seen    = 1'b1;
                        res_valid = 1'b1;
                        kind      = KIND_FORMAT;
                    end
                end
                n_left = r_left - 32'd1;
                if (left_end) begin
                    n_phase = PH_ID2;
                end
            end
            PH_SKIP1, PH_SKIP2: begin
                n_left = r_left - 32'd1;
                if (left_end) begin
                    n_phase = (r_phase == PH_SKIP1) ? PH_ID1 : PH_ID2;
                end
            end
            PH_SZ2: begin
                n_size = size_in;
                n_idx  = r_idx + 2'd1;
                if (hdr_done) begin
                    if (r_tag == TAG_DATA) begin
                        res_valid = 1'b1;
                        kind      = KIND_DATA;
                        dsize     = size_in;
                        if (size_in == 32'd0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_left  = size_in;
                            n_phase = PH_DATA;
                        end
                    end else if (size_in == 32'd0) begin
                        n_phase = PH_ID2;
                    end else begin
                        n_left  = size_in;
                        n_phase = PH_SKIP2;
                    end
                end
            end
            PH_DATA: begin
                res_valid = 1'b1;
                kind      = KIND_SAMPLE;
                sample    = i_byte;
                n_left    = r_left - 32'd1;
                if (left_end) begin
                    last    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Error for a stream that ends early, judged on the phase reached
    always_comb begin
        err_valid = 1'b1;
        err_kind  = KIND_NO_DATA;
        priority if (n_phase == PH_RIFF || n_phase == PH_RSIZE) begin
            err_kind = KIND_BAD_RIFF;
        end else if (n_phase == PH_WAVE) begin
            err_kind = KIND_BAD_WAVE;
        end else if (n_phase >= PH_ID1 && n_phase <= PH_SKIP1) begin
            err_kind = KIND_NO_FMT;
        end else if (n_phase >= PH_ID2 && n_phase <= PH_SKIP2) begin
            err_kind = KIND_NO_DATA;
        end else begin
            err_valid = 1'b0;
        end
    end

    // Result record; format fields come from the updated store
    always_comb begin
        o_res_valid = i_accept && (res_valid || (i_eos && err_valid));
        o_res       = '0;
        if (i_eos && err_valid) begin
            o_res.kind = err_kind;
        end else begin
            o_res.kind        = kind;
            o_res.sample_byte = sample;
            o_res.last_sample = last;
            o_res.data_size   = dsize;
        end
        if (n_seen) begin
            o_res.format_tag    = {n_store[1], n_store[0]};
            o_res.channel_count = {n_store[3], n_store[2]};
            o_res.sample_rate   = {n_store[7], n_store[6], n_store[5], n_store[4]};
            o_res.byte_rate     = {n_store[11], n_store[10], n_store[9], n_store[8]};
            o_res.block_align   = {n_store[13], n_store[12]};
            o_res.sample_bits   = {n_store[15], n_store[14]};
            o_res.extra_size    = {n_store[17], n_store[16]};
        end
    end

    // State update; end of stream returns everything to the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_eos)) begin
            r_phase <= PH_RIFF;
            r_idx   <= '0;
            r_tag   <= '0;
            r_size  <= '0;
            r_left  <= '0;
            r_pos   <= '0;
            r_cap   <= '0;
            r_seen  <= 1'b0;
            for (int i = 0; i < FMT_CAP; i++) begin
                r_store[i] <= 8'd0;
            end
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_tag   <= n_tag;
            r_size  <= n_size;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_cap   <= n_cap;
            r_seen  <= n_seen;
            r_store <= n_store;
        end
    end

endmodule

### hdl/rwsp_out_stage.sv
// Output register of the parser: holds one result until the receiver takes it.
// Depends on rwsp_pkg.
module rwsp_out_stage
    import rwsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_tready,
    output logic    o_space,
    output logic    o_tvalid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Room for a new result when empty or when the held one leaves now
    assign o_space  = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_res    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### hdl/riff_wave_stream_parser.sv
// RIFF/WAVE stream parser, top level.
// Depends on rwsp_pkg, rwsp_parser and rwsp_out_stage.
//
// Usage:
//   The slave stream carries the WAV file one byte per request: tdata holds
//   the byte, tlast marks the final byte of the file. The master stream
//   carries results: tuser holds the kind (sample byte, format ready, data
//   start or one of four errors), tlast marks the last byte of the data
//   chunk, tdata holds the sample byte, data size and the fmt fields.
//   Bytes that produce no result (tags, sizes, skipped chunks) are simply
//   consumed.
//   A result is registered and shows on the master side in the cycle after
//   its byte is accepted. Throughput: one byte per cycle unless stalled,
//   as the single output register reloads in the same cycle it empties.
//   Reset clears the parse state and drops any held result; the first byte
//   after reset is taken as the start of a file. A tlast byte returns the
//   parser to that start state after its result is formed.
//   When the receiver stalls with a result held, s_axis_tready falls and
//   input bytes wait; nothing is dropped.
module riff_wave_stream_parser
    import rwsp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] stream_byte
    input  logic         s_axis_tlast,   // end_of_stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] sample_byte, [39:8] data_size, [55:40] format_tag,
    // [71:56] channel_count, [103:72] sample_rate, [135:104] byte_rate,
    // [151:136] block_align, [167:152] sample_bits, [183:168] extra_size
    output logic [183:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // [2:0] kind
    output logic         m_axis_tlast    // last_sample
);

    logic    in_accept;
    logic    space;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign s_axis_tready = space;
    assign in_accept     = s_axis_tvalid && space;

    rwsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (s_axis_tdata),
        .i_eos       (s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rwsp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_res    (res),
        .i_tready (m_axis_tready),
        .o_space  (space),
        .o_tvalid (m_axis_tvalid),
        .o_res    (out_res)
    );

    // Pack the result, first field lowest
    assign m_axis_tdata = {out_res.extra_size, out_res.sample_bits, out_res.block_align,
                           out_res.byte_rate, out_res.sample_rate, out_res.channel_count,
                           out_res.format_tag, out_res.data_size, out_res.sample_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_sample;

endmodule

### hdl/rwsp_checker.sv
// Port-level checks for the RIFF/WAVE stream parser, bound to the top level.
// Depends on rwsp_pkg and riff_wave_stream_parser.
module rwsp_checker
    import rwsp_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [183:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Input is never blocked while the output register is empty
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Last marker only on sample bytes
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_SAMPLE)
        else $error("last marker on a non-sample result");

    // Data size is zero except on data start
    a_dsize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[39:8] == 32'd0)
        else $error("data size on wrong kind");

    // Sample byte is zero except on sample results
    a_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_SAMPLE |-> m_axis_tdata[7:0] == 8'd0)
        else $error("sample byte on wrong kind");

endmodule

bind riff_wave_stream_parser rwsp_checker u_rwsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### test/rwsp_stream_checker.sv
`timescale 1ns / 1ps
// Result checker for the RIFF/WAVE stream parser: watches both streams,
// predicts each result from the accepted bytes and compares field by field.
// Depends on rwsp_pkg only.
module rwsp_stream_checker
    import rwsp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_byte_valid,
    input  logic         i_byte_ready,
    input  logic [7:0]   i_byte,        // [7:0] stream_byte
    input  logic         i_byte_last,   // end_of_stream
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [183:0] i_res_data,    // sample_byte up to extra_size, as on the block
    input  logic [2:0]   i_res_kind,    // [2:0] kind
    input  logic         i_res_last,    // last_sample
    output int           o_pending,
    output int           o_mismatches
);

    // Where the parser stands in the file
    typedef enum logic [3:0] {
        P_RIFF_TAG, P_RIFF_SIZE, P_WAVE_TAG, P_ID_PRE, P_SIZE_PRE, P_FMT_BODY,
        P_SKIP_PRE, P_ID_POST, P_SIZE_POST, P_SKIP_POST, P_SAMPLES, P_IGNORE
    } t_parse_phase;

    t_parse_phase phase;
    logic [2:0]   hdr_idx;
    logic [31:0]  tag_sr;
    logic [31:0]  size_acc;
    logic [31:0]  remaining;
    logic [7:0]   fmt_bytes [FMT_CAP];
    logic         fmt_seen;
    t_result      expected_q [$];
    int           mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic void clear_parser();
        phase     = P_RIFF_TAG;
        hdr_idx   = '0;
        tag_sr    = '0;
        size_acc  = '0;
        remaining = '0;
        fmt_seen  = 1'b0;
        foreach (fmt_bytes[k]) fmt_bytes[k] = '0;
    endfunction

    // Shift one tag (msb first) or size (little-endian) byte; true on the fourth
    function automatic logic header_byte_done(input logic [7:0] b, input logic is_size);
        if (is_size) size_acc = {b, size_acc[31:8]};
        else         tag_sr   = {tag_sr[23:0], b};
        hdr_idx = hdr_idx + 3'd1;
        if (hdr_idx >= 3'd4) begin
            hdr_idx = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the parse by one byte and form the result it causes, if any
    task automatic parse_wave_byte(input logic [7:0] b, input logic eos,
                                   output logic produced, output t_result res);
        logic [31:0] pos;
        logic [31:0] cap;
        logic [2:0]  err;
        logic        has_err;
        produced = 1'b0;
        res      = '0;
        has_err  = 1'b0;
        err      = KIND_SAMPLE;
        case (phase)
            P_RIFF_TAG: if (header_byte_done(b, 1'b0)) begin
                if (tag_sr == TAG_RIFF) phase = P_RIFF_SIZE;
                else begin
                    produced = 1'b1; res.kind = KIND_BAD_RIFF; phase = P_IGNORE;
                end
            end
            P_RIFF_SIZE: if (header_byte_done(b, 1'b1)) phase = P_WAVE_TAG;
            P_WAVE_TAG: if (header_byte_done(b, 1'b0)) begin
                if (tag_sr == TAG_WAVE) phase = P_ID_PRE;
                else begin
                    produced = 1'b1; res.kind = KIND_BAD_WAVE; phase = P_IGNORE;
                end
            end
            P_ID_PRE: if (header_byte_done(b, 1'b0)) phase = P_SIZE_PRE;
            P_SIZE_PRE: if (header_byte_done(b, 1'b1)) begin
                if (tag_sr == TAG_FMT) begin
                    foreach (fmt_bytes[k]) fmt_bytes[k] = '0;
                    if (size_acc == 0) begin
                        fmt_seen = 1'b1; produced = 1'b1; res.kind = KIND_FORMAT;
                        phase = P_ID_POST;
                    end else begin
                        remaining = size_acc; phase = P_FMT_BODY;
                    end
                end else if (size_acc == 0) phase = P_ID_PRE;
                else begin
                    remaining = size_acc; phase = P_SKIP_PRE;
                end
            end
            // capture at most FMT_CAP bytes, report on the last one captured
            P_FMT_BODY: begin
                pos = size_acc - remaining;
                cap = (size_acc < FMT_CAP) ? size_acc : FMT_CAP;
                if (pos < FMT_CAP) fmt_bytes[pos[FMT_POS_W-1:0]] = b;
                remaining = remaining - 1;
                if (pos + 1 == cap) begin
                    fmt_seen = 1'b1; produced = 1'b1; res.kind = KIND_FORMAT;
                end
                if (remaining == 0) phase = P_ID_POST;
            end
            P_SKIP_PRE: begin
                remaining = remaining - 1;
                if (remaining == 0) phase = P_ID_PRE;
            end
            P_ID_POST: if (header_byte_done(b, 1'b0)) phase = P_SIZE_POST;
            P_SIZE_POST: if (header_byte_done(b, 1'b1)) begin
                if (tag_sr == TAG_DATA) begin
                    produced = 1'b1; res.kind = KIND_DATA; res.data_size = size_acc;
                    if (size_acc == 0) phase = P_IGNORE;
                    else begin
                        remaining = size_acc; phase = P_SAMPLES;
                    end
                end else if (size_acc == 0) phase = P_ID_POST;
                else begin
                    remaining = size_acc; phase = P_SKIP_POST;
                end
            end
            P_SKIP_POST: begin
                remaining = remaining - 1;
                if (remaining == 0) phase = P_ID_POST;
            end
            P_SAMPLES: begin
                produced = 1'b1; res.kind = KIND_SAMPLE; res.sample_byte = b;
                remaining = remaining - 1;
                if (remaining == 0) begin
                    res.last_sample = 1'b1; phase = P_IGNORE;
                end
            end
            default: phase = P_IGNORE;
        endcase

        // end of file: an unfinished structure overrides any result of this byte
        if (eos) begin
            case (phase)
                P_RIFF_TAG, P_RIFF_SIZE: begin has_err = 1'b1; err = KIND_BAD_RIFF; end
                P_WAVE_TAG:              begin has_err = 1'b1; err = KIND_BAD_WAVE; end
                P_ID_PRE, P_SIZE_PRE, P_FMT_BODY, P_SKIP_PRE: begin
                    has_err = 1'b1; err = KIND_NO_FMT;
                end
                P_ID_POST, P_SIZE_POST, P_SKIP_POST: begin
                    has_err = 1'b1; err = KIND_NO_DATA;
                end
                default: ;
            endcase
            if (has_err) begin
                produced = 1'b1;
                res      = '0;
                res.kind = err;
            end
        end

        if (produced && fmt_seen) begin
            res.format_tag    = {fmt_bytes[1], fmt_bytes[0]};
            res.channel_count = {fmt_bytes[3], fmt_bytes[2]};
            res.sample_rate   = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
            res.byte_rate     = {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9], fmt_bytes[8]};
            res.block_align   = {fmt_bytes[13], fmt_bytes[12]};
            res.sample_bits   = {fmt_bytes[15], fmt_bytes[14]};
            res.extra_size    = {fmt_bytes[17], fmt_bytes[16]};
        end

        if (eos) clear_parser();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare results first, then take the new request: results trail their bytes
    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        logic    produced;
        if (!i_rst_n) begin
            clear_parser();
            expected_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                seen.kind          = i_res_kind;
                seen.sample_byte   = i_res_data[7:0];
                seen.last_sample   = i_res_last;
                seen.data_size     = i_res_data[39:8];
                seen.format_tag    = i_res_data[55:40];
                seen.channel_count = i_res_data[71:56];
                seen.sample_rate   = i_res_data[103:72];
                seen.byte_rate     = i_res_data[135:104];
                seen.block_align   = i_res_data[151:136];
                seen.sample_bits   = i_res_data[167:152];
                seen.extra_size    = i_res_data[183:168];
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual kind %0h",
                             $time, seen.kind);
                end else begin
                    want = expected_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(seen.kind));
                    check_field("sample_byte", 32'(want.sample_byte), 32'(seen.sample_byte));
                    check_field("last_sample", 32'(want.last_sample), 32'(seen.last_sample));
                    check_field("data_size", want.data_size, seen.data_size);
                    check_field("format_tag", 32'(want.format_tag), 32'(seen.format_tag));
                    check_field("channel_count", 32'(want.channel_count),
                                32'(seen.channel_count));
                    check_field("sample_rate", want.sample_rate, seen.sample_rate);
                    check_field("byte_rate", want.byte_rate, seen.byte_rate);
                    check_field("block_align", 32'(want.block_align), 32'(seen.block_align));
                    check_field("sample_bits", 32'(want.sample_bits), 32'(seen.sample_bits));
                    check_field("extra_size", 32'(want.extra_size), 32'(seen.extra_size));
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                parse_wave_byte(i_byte, i_byte_last, produced, want);
                if (produced) expected_q.push_back(want);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

### test/tb_riff_wave_stream_parser.sv
`timescale 1ns / 1ps
// Testbench top for the RIFF/WAVE stream parser: builds WAV byte streams,
// drives them with random gaps and back-pressure, and reports the verdict.
// Depends on rwsp_pkg, riff_wave_stream_parser and rwsp_stream_checker.
module tb_riff_wave_stream_parser;
    import rwsp_pkg::*;

    localparam int BODY_PER_PHASE = 160;
    localparam int LONG_HOLD      = 60;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;    // [7:0] stream_byte
    logic         s_axis_tlast = 1'b0;  // end_of_stream
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [183:0] m_axis_tdata;         // sample_byte, data_size, fmt fields
    logic [2:0]   m_axis_tuser;         // [2:0] kind
    logic         m_axis_tlast;         // last_sample

    int pending;
    int fail_count;
    int src_idle_pct  = 31;
    int sink_idle_pct = 84;
    int hold_requests = 0;
    int holds_done    = 0;
    int body_bytes    = 0;

    logic [7:0] file_q [$];

    riff_wave_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rwsp_stream_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .i_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_byte_last  (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_kind   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_pending    (pending),
        .o_mismatches (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, plus a long counted hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // One byte request; valid stays high into the next request unless idling
    task automatic send_byte(input logic [7:0] value, input logic eos);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_file();
        for (int k = 0; k < file_q.size(); k++) send_byte(file_q[k], k == file_q.size() - 1);
    endtask

    // Stop offering and wait until every predicted result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    function automatic void put_word(input logic [31:0] w, input logic msb_first);
        for (int k = 0; k < 4; k++)
            file_q.push_back(msb_first ? w[31 - 8 * k -: 8] : w[8 * k +: 8]);
    endfunction

    function automatic void put_chunk(input logic [31:0] id, input logic [31:0] decl,
                                      input int given);
        put_word(id, 1'b1);
        put_word(decl, 1'b0);
        repeat (given) file_q.push_back(8'($urandom_range(255)));
    endfunction

    // Id of a chunk to be skipped: random or a chosen tag, never the one that matters
    function automatic logic [31:0] filler_id(input logic [31:0] avoid, input logic [31:0] alt);
        logic [31:0] id;
        id = ($urandom_range(3) == 0) ? alt : $urandom;
        if (id == avoid) id[0] = ~id[0];
        return id;
    endfunction

    function automatic void build_wave(input int fmt_len, input int pre, input int post,
                                       input logic [31:0] data_decl, input int data_given,
                                       input int trail, input int max_fill);
        int fill;
        file_q.delete();
        put_word(TAG_RIFF, 1'b1);
        put_word($urandom, 1'b0);
        put_word(TAG_WAVE, 1'b1);
        repeat (pre) begin
            fill = $urandom_range(max_fill);
            put_chunk(filler_id(TAG_FMT, TAG_DATA), fill, fill);
        end
        put_chunk(TAG_FMT, fmt_len, fmt_len);
        repeat (post) begin
            fill = $urandom_range(max_fill);
            put_chunk(filler_id(TAG_DATA, TAG_FMT), fill, fill);
        end
        put_chunk(TAG_DATA, data_decl, data_given);
        repeat (trail) file_q.push_back(8'($urandom_range(255)));
    endfunction

    // Keep the first n bytes, so the file ends early
    function automatic void cut_file(input int n);
        while (file_q.size() > n) file_q.delete(file_q.size() - 1);
    endfunction

    initial begin
        int pick;
        int fmt_len;
        int given;
        int pos;
        logic [31:0] decl;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wrong form tags, bytes after them ignored
        file_q.delete();
        put_word(32'h5249_4658, 1'b1);
        send_file();
        file_q.delete();
        put_word(TAG_RIFF, 1'b1);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'h5741_5658, 1'b1);
        put_word(32'h0, 1'b0);
        send_file();

        // file ends inside the RIFF tag, its size, the WAVE tag, and just after
        for (int c = 0; c < 4; c++) begin
            build_wave(16, 0, 0, 4, 4, 0, 0);
            cut_file(c == 3 ? 12 : 4 * c + 2);
            send_file();
        end

        // zero-size skipped chunks both sides of fmt, extreme sample bytes
        build_wave(16, 2, 2, 2, 2, 0, 0);
        file_q[file_q.size() - 2] = 8'h00;
        file_q[file_q.size() - 1] = 8'hFF;
        send_file();

        // fmt chunk sizes: empty, short, plain, odd, extended, over-long
        for (int c = 0; c < 6; c++) begin
            case (c)
                0: fmt_len = 0;
                1: fmt_len = 5;
                2: fmt_len = 16;
                3: fmt_len = 17;
                4: fmt_len = 18;
                default: fmt_len = 20;
            endcase
            build_wave(fmt_len, 0, 0, 3, 3, 2, 0);
            send_file();
        end

        // empty data chunk followed by ignored bytes
        build_wave(18, 0, 0, 0, 0, 3, 0);
        send_file();

        // end on the last fmt byte, and inside an over-long fmt after capture
        build_wave(16, 0, 0, 4, 4, 0, 0);
        cut_file(36);
        send_file();
        build_wave(24, 0, 0, 4, 4, 0, 0);
        cut_file(38);
        send_file();

        // end inside a skipped chunk before and after fmt
        build_wave(16, 1, 0, 4, 4, 0, 6);
        cut_file(21);
        send_file();
        build_wave(16, 0, 1, 4, 4, 0, 6);
        cut_file(41);
        send_file();

        // huge data size, payload cut short
        build_wave(16, 0, 0, 32'hFFFF_FFFF, 3, 0, 0);
        send_file();
        drain_results();

        // random files under three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                src_idle_pct  = 84;
                sink_idle_pct = 31;
            end else if (ph == 2) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                // long receiver hold-off while a sample-heavy file keeps coming
                hold_requests++;
                build_wave(16, 0, 0, 48, 48, 0, 0);
                send_file();
                drain_results();
            end
            while (body_bytes < (ph + 1) * BODY_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 85) begin
                    fmt_len = $urandom_range(1) ? 16 : ($urandom_range(1) ? 18 : $urandom_range(24));
                    given   = $urandom_range(24);
                    decl    = ($urandom_range(9) == 0) ? $urandom : given;
                    build_wave(fmt_len, $urandom_range(2), $urandom_range(2), decl, given,
                               ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, 6);
                    body_bytes += file_q.size();
                    if (pick >= 70) begin
                        // broken header: one flipped bit near the start
                        pos = $urandom_range(39) % file_q.size();
                        file_q[pos] = file_q[pos] ^ (8'h01 << $urandom_range(7));
                    end else if ($urandom_range(6) == 0) begin
                        cut_file($urandom_range(1, file_q.size()));
                    end
                end else begin
                    // noise, sometimes behind a valid RIFF tag
                    file_q.delete();
                    if ($urandom_range(1)) put_word(TAG_RIFF, 1'b1);
                    repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom_range(255)));
                    body_bytes += file_q.size();
                end
                send_file();
            end
            drain_results();
        end

        repeat (5) @(negedge i_clk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
